/* rtl/pcu_pkg.sv */
// Shared constants for the path cosine upsampler.
package pcu_pkg;

  localparam int SUB_W                   = 6;
  localparam logic [SUB_W-1:0] SUB_RESET = 6'd8;
  localparam int MAX_SUBDIVISION_DEF     = 32;
  localparam int COS_TABLE_SIZE_DEF      = 256;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = 17;
  localparam int WEIGHT_W = 16;
  localparam int MUL_A_W  = 17;
  localparam int PROD_W   = MUL_A_W + DIFF_W;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

endpackage

/* rtl/pcu_cos_rom.sv */
// Cosine weight ROM with a registered read port.
module pcu_cos_rom
  import pcu_pkg::*;
#(
  parameter int COS_SIZE = COS_TABLE_SIZE_DEF,
  localparam int AW = $clog2(COS_SIZE)
) (
  input  logic                clk,
  input  logic [AW-1:0]       addr,
  output logic [WEIGHT_W-1:0] weight
);

  typedef logic [WEIGHT_W-1:0] rom_t [COS_SIZE];

  localparam logic [63:0] HALF_TURN = 64'(2 * COS_SIZE);

  function automatic rom_t build_rom();
    rom_t              tbl;
    logic [63:0]       a;
    logic [63:0]       t;
    logic [63:0]       su;
    logic [63:0]       sq;
    logic [63:0]       w;
    logic signed [63:0] s;
    for (int k = 0; k < COS_SIZE; k++) begin
      a = (PI_Q30 * 64'(k)) / HALF_TURN;
      t = a;
      s = signed'(a);
      for (int m = 1; m <= 6; m++) begin
        t = (t * a) >> 30;
        t = (t * a) >> 30;
        unique case (m)
          1:       t = t / 64'd6;
          2:       t = t / 64'd20;
          3:       t = t / 64'd42;
          4:       t = t / 64'd72;
          5:       t = t / 64'd110;
          default: t = t / 64'd156;
        endcase
        if (m[0]) begin
          s = s - signed'(t);
        end else begin
          s = s + signed'(t);
        end
      end
      if (s < 0) begin
        s = '0;
      end
      if (s > signed'(ONE_Q30)) begin
        s = signed'(ONE_Q30);
      end
      su = s;
      sq = su * su;
      w  = (sq + (64'd1 << 44)) >> 45;
      if (w > 64'd32768) begin
        w = 64'd32768;
      end
      tbl[k] = w[WEIGHT_W-1:0];
    end
    return tbl;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  always_ff @(posedge clk) begin
    weight <= ROM_DATA[addr];
  end

endmodule

/* rtl/pcu_div.sv */
// Bit-serial restoring divider for unsigned operands.
module pcu_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* rtl/path_cosine_upsampler.sv */
// Top level of the path cosine upsampler: sequencer, shared multiplier and output register.
// For each subdivision point, the one bit-serial divider works out the y step and the ROM
// index in turn.
// A point with a held predecessor yields n subdivision words; an end point adds one more
// word. The input is not ready while a point is being worked on.
// Synchronous active-low reset: subdivision returns to 8 and no point is held.
module path_cosine_upsampler
  import pcu_pkg::*;
#(
  parameter int MAX_SUBDIVISION   = MAX_SUBDIVISION_DEF,
  parameter int COS_TABLE_SIZE    = COS_TABLE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [SUB_W-1:0]          cfg_subdivision,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic                      in_end_of_path,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_last_of_run
);

  localparam int NW    = $clog2(MAX_SUBDIVISION + 1);
  localparam int AW    = $clog2(COS_TABLE_SIZE);
  localparam int DIV_W = (NW + 19 > NW + AW + 1) ? NW + 19 : NW + AW + 1;
  localparam int DD_W  = NW + 1;
  localparam int YN_W  = PROD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_YMUL, S_YDIV, S_YWAIT, S_KDIV, S_KWAIT, S_ROM, S_XMUL, S_EMIT, S_END
  } state_t;

  state_t                    state_r;
  logic [SUB_W-1:0]          sub_r;
  logic [NW-1:0]             n_r;
  logic [NW-1:0]             j_r;
  logic                      have_prev_r;
  logic                      last_r;
  logic signed [COORD_W-1:0] prev_x_r;
  logic signed [COORD_W-1:0] prev_y_r;
  logic signed [COORD_W-1:0] cur_x_r;
  logic signed [COORD_W-1:0] cur_y_r;
  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      yneg_r;
  logic [COORD_W-1:0]        y_r;
  logic [AW-1:0]             k_r;
  logic                      out_valid_r;
  logic [COORD_W-1:0]        out_x_r;
  logic [COORD_W-1:0]        out_y_r;
  logic                      out_last_r;

  logic [NW-1:0]             n_calc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [YN_W-1:0]    ynum;
  logic [YN_W-1:0]           ymag;
  logic                      div_start;
  logic [DIV_W-1:0]          div_num;
  logic [DIV_W-1:0]          div_den_num;
  logic [DD_W-1:0]           div_den;
  logic                      div_done;
  logic [DIV_W-1:0]          div_quo;
  logic [DD_W-1:0]           div_rem;
  logic [COORD_W-1:0]        yq;
  logic [WEIGHT_W-1:0]       rom_w;
  logic signed [PROD_W-1:0]  xr;
  logic signed [PROD_W-1:0]  xs;
  logic [COORD_W-1:0]        ox;
  logic                      out_free;
  logic                      seg_last;
  logic                      word_load;

  always_comb begin
    if (sub_r == '0) begin
      n_calc = NW'(1);
    end else if (SUB_W'(MAX_SUBDIVISION) < sub_r) begin
      n_calc = NW'(MAX_SUBDIVISION);
    end else begin
      n_calc = sub_r[NW-1:0];
    end
  end

  // The one multiplier serves 2*j*dy for y and weight*dx for x.
  assign mul_a = (state_r == S_YMUL) ? signed'(MUL_A_W'({j_r, 1'b0}))
                                      : signed'(MUL_A_W'(rom_w));
  assign mul_b = (state_r == S_YMUL) ? dy_r : dx_r;
  assign mul_p = mul_a * mul_b;

  assign ynum = signed'({prod_r[PROD_W-1], prod_r}) + signed'(YN_W'(n_r));
  assign ymag = ynum[YN_W-1] ? YN_W'(-ynum) : YN_W'(ynum);

  assign div_start   = (state_r == S_YDIV) || (state_r == S_KDIV);
  assign div_den_num = DIV_W'(j_r) * DIV_W'(COS_TABLE_SIZE);
  assign div_num     = (state_r == S_YDIV) ? ymag[DIV_W-1:0] : div_den_num;
  assign div_den     = (state_r == S_YDIV) ? {n_r, 1'b0} : DD_W'(n_r);

  pcu_div #(
    .NUM_W(DIV_W),
    .DEN_W(DD_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  pcu_cos_rom #(
    .COS_SIZE(COS_TABLE_SIZE)
  ) u_rom (
    .clk   (clk),
    .addr  (k_r),
    .weight(rom_w)
  );

  // Floor division: a negative quotient with a remainder rounds one further down.
  assign yq = yneg_r ? COORD_W'(-(div_quo[COORD_W-1:0] + COORD_W'(div_rem != '0)))
                     : div_quo[COORD_W-1:0];

  assign xr = prod_r + PROD_W'(16384);
  assign xs = xr >>> 15;
  assign ox = COORD_W'(prev_x_r) + xs[COORD_W-1:0];

  assign out_free  = !out_valid_r || out_ready;
  assign seg_last  = (j_r == n_r - NW'(1));
  assign word_load = out_free && (state_r == S_EMIT || state_r == S_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= SUB_RESET;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
      n_r         <= NW'(1);
      j_r         <= '0;
    end else begin
      if (cfg_valid) begin
        sub_r <= cfg_subdivision;
      end
      if (word_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cur_x_r <= in_point_x;
            cur_y_r <= in_point_y;
            last_r  <= in_end_of_path;
            dx_r    <= DIFF_W'(in_point_x) - DIFF_W'(prev_x_r);
            dy_r    <= DIFF_W'(in_point_y) - DIFF_W'(prev_y_r);
            n_r     <= n_calc;
            j_r     <= '0;
            if (have_prev_r) begin
              state_r <= S_YMUL;
            end else if (in_end_of_path) begin
              state_r <= S_END;
            end else begin
              prev_x_r    <= in_point_x;
              prev_y_r    <= in_point_y;
              have_prev_r <= 1'b1;
            end
          end
        end
        S_YMUL: begin
          prod_r  <= mul_p;
          state_r <= S_YDIV;
        end
        S_YDIV: begin
          yneg_r  <= ynum[YN_W-1];
          state_r <= S_YWAIT;
        end
        S_YWAIT: begin
          if (div_done) begin
            y_r     <= COORD_W'(prev_y_r) + yq;
            state_r <= S_KDIV;
          end
        end
        S_KDIV: begin
          state_r <= S_KWAIT;
        end
        S_KWAIT: begin
          if (div_done) begin
            k_r     <= div_quo[AW-1:0];
            state_r <= S_ROM;
          end
        end
        S_ROM: begin
          state_r <= S_XMUL;
        end
        S_XMUL: begin
          prod_r  <= mul_p;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_x_r     <= ox;
            out_y_r     <= y_r;
            out_last_r  <= seg_last && !last_r;
            j_r         <= j_r + NW'(1);
            if (!seg_last) begin
              state_r <= S_YMUL;
            end else if (last_r) begin
              state_r <= S_END;
            end else begin
              prev_x_r    <= cur_x_r;
              prev_y_r    <= cur_y_r;
              have_prev_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            out_x_r     <= cur_x_r;
            out_y_r     <= cur_y_r;
            out_last_r  <= 1'b1;
            prev_x_r    <= cur_x_r;
            prev_y_r    <= cur_y_r;
            have_prev_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_last_of_run = out_last_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_YWAIT || state_r == S_KWAIT))
    else $error("divider finished outside a wait state");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_END) |-> (j_r < n_r && n_r != '0))
    else $error("subdivision step out of range");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    else $error("pending result word overwritten");

endmodule
